/* rtl/variable_width_packed_index_store_macros.svh */
// Assertion macros for the packed index store checker.
// Needs clk and rst_n in the scope of each use.
`ifndef VARIABLE_WIDTH_PACKED_INDEX_STORE_MACROS_SVH
`define VARIABLE_WIDTH_PACKED_INDEX_STORE_MACROS_SVH

// same-cycle implication
`define VWPIS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define VWPIS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/vwpis_pkg.sv */
// Shared types, constants and functions of the packed index store.
// No dependencies.
package vwpis_pkg;

    localparam int ENTRIES_DEF   = 32768;
    localparam int WORD_BITS_DEF = 64;
    localparam int Q_DEPTH       = 2;

    localparam logic [2:0] CODE_W1  = 3'd0;
    localparam logic [2:0] CODE_W2  = 3'd1;
    localparam logic [2:0] CODE_W4  = 3'd2;
    localparam logic [2:0] CODE_W8  = 3'd3;
    localparam logic [2:0] CODE_W16 = 3'd4;

    localparam logic [15:0] CNT_W8  = 16'd256;
    localparam logic [15:0] CNT_W4  = 16'd16;
    localparam logic [15:0] CNT_W2  = 16'd4;
    localparam logic [15:0] CNT_W1  = 16'd2;

    typedef enum logic [1:0] {
        CMD_READ    = 2'd0,
        CMD_WRITE   = 2'd1,
        CMD_RESERVE = 2'd2,
        CMD_NOP     = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t        op;
        logic [14:0] position;
        logic [15:0] value;
        logic [15:0] distinct_count;
        logic        in_range;
    } job_t;

    typedef struct packed {
        logic [15:0] read_value;
        logic        status;
        logic [2:0]  width_code;
    } result_t;

    function automatic logic [2:0] required_code(input logic [15:0] cnt);
        logic [2:0] code;
        priority if (cnt > CNT_W8) code = CODE_W16;
        else if (cnt > CNT_W4)     code = CODE_W8;
        else if (cnt > CNT_W2)     code = CODE_W4;
        else if (cnt > CNT_W1)     code = CODE_W2;
        else                       code = CODE_W1;
        return code;
    endfunction

    function automatic logic value_fits(input logic [15:0] val, input logic [2:0] code);
        logic fits;
        unique case (code)
            CODE_W1: fits = (val[15:1] == 15'd0);
            CODE_W2: fits = (val[15:2] == 14'd0);
            CODE_W4: fits = (val[15:4] == 12'd0);
            CODE_W8: fits = (val[15:8] == 8'd0);
            default: fits = 1'b1;
        endcase
        return fits;
    endfunction

endpackage

/* rtl/vwpis_if.sv */
// Request and response channel interfaces of the packed index store.
// No dependencies.
interface vwpis_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [14:0] position;
    logic [15:0] value;
    logic [15:0] distinct_count;

    modport source (output valid, command, position, value, distinct_count, input ready);
    modport sink   (input valid, command, position, value, distinct_count, output ready);
endinterface

interface vwpis_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] read_value;
    logic        status;
    logic [2:0]  width_code;

    modport source (output valid, read_value, status, width_code, input ready);
    modport sink   (input valid, read_value, status, width_code, output ready);
endinterface

/* rtl/variable_width_packed_index_store.sv */
// Top level of the variable-width packed index store.
// Depends on vwpis_pkg, vwpis_if, vwpis_front, vwpis_queue and vwpis_back.
//
// Channels: req carries one command word (read, write, reserve or no-op); rsp returns
// exactly one result word per request, in request order.
// Flow: an in-range read or an accepted write passes the ACCESS state before its
// result; a rejected write, a no-op or a reserve that does not widen is answered
// from idle. Reads and writes use a registered memory read, then extract or
// merge and write back; the back end takes no new word until it is back in idle.
// A widening reserve walks the store one packed word per cycle, top word first.
// A two-deep queue between front and back lets req fill while the back end
// works; rsp is a register, so a stalled receiver holds the result and the
// back end takes no further word until it is free.
// Reset: the width falls to one bit and a clearing pass zeroes the store,
// during which req.ready stays low.
module variable_width_packed_index_store
    import vwpis_pkg::*;
#(
    parameter int ENTRIES   = ENTRIES_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF
)
(
    input logic          clk,
    input logic          rst_n,
    vwpis_req_if.sink    req,
    vwpis_rsp_if.source  rsp
);

    logic clearing;
    logic q_full;
    logic q_empty;
    logic push;
    logic pop;
    job_t push_job;
    job_t head_job;

    vwpis_front #(
        .ENTRIES (ENTRIES)
    ) u_front (
        .req      (req),
        .clearing (clearing),
        .q_full   (q_full),
        .push     (push),
        .job      (push_job)
    );

    vwpis_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_job),
        .full      (q_full),
        .pop       (pop),
        .pop_data  (head_job),
        .empty     (q_empty)
    );

    vwpis_back #(
        .ENTRIES   (ENTRIES),
        .WORD_BITS (WORD_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .job      (head_job),
        .job_vld  (!q_empty),
        .job_pop  (pop),
        .clearing (clearing),
        .rsp      (rsp)
    );

endmodule

/* rtl/vwpis_queue.sv */
// Short job queue between front and back of the packed index store.
// Depends on vwpis_pkg.
module vwpis_queue
    import vwpis_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_data,
    output logic full,
    input  logic pop,
    output job_t pop_data,
    output logic empty
);

    localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

    job_t          slots [Q_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW:0]   count_reg;

    assign full     = (count_reg == (PW+1)'(Q_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = slots[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* rtl/vwpis_front.sv */
// Front end: takes request words, decodes command and range, feeds the queue.
// Depends on vwpis_pkg and vwpis_if.
module vwpis_front
    import vwpis_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
)
(
    vwpis_req_if.sink req,
    input  logic      clearing,
    input  logic      q_full,
    output logic      push,
    output job_t      job
);

    cmd_t op;

    always_comb
    begin
        unique case (req.command)
            CMD_READ:    op = CMD_READ;
            CMD_WRITE:   op = CMD_WRITE;
            CMD_RESERVE: op = CMD_RESERVE;
            default:     op = CMD_NOP;
        endcase
    end

    assign req.ready          = !q_full && !clearing;
    assign push               = req.valid && req.ready;
    assign job.op             = op;
    assign job.position       = req.position;
    assign job.value          = req.value;
    assign job.distinct_count = req.distinct_count;
    assign job.in_range       = ({2'b00, req.position} < 17'(ENTRIES));

endmodule

/* rtl/vwpis_back.sv */
// Back end: packed word memory, entry access, widening repack and clearing pass.
// Depends on vwpis_pkg and vwpis_if.
module vwpis_back
    import vwpis_pkg::*;
#(
    parameter int ENTRIES   = ENTRIES_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  job_t       job,
    input  logic       job_vld,
    output logic       job_pop,
    output logic       clearing,
    vwpis_rsp_if.source rsp
);

    localparam int LOG_WB = $clog2(WORD_BITS);
    localparam int WORDS  = ENTRIES * 16 / WORD_BITS;
    localparam int AW     = $clog2(WORDS);

    typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_ACCESS, ST_REPACK} state_t;

    logic [WORD_BITS-1:0] mem [WORDS];
    logic [WORD_BITS-1:0] rdata_reg;

    state_t            state_reg;
    logic [2:0]        width_reg;
    logic [2:0]        new_code_reg;
    logic [AW-1:0]     clr_addr_reg;
    logic [AW-1:0]     rp_addr_reg;
    logic              rp_issue_reg;
    logic              rp_wvld_reg;
    logic [AW-1:0]     rp_waddr_reg;
    job_t              acc_reg;
    logic [AW-1:0]     acc_word_reg;
    logic [LOG_WB-1:0] acc_off_reg;
    logic              rsp_vld_reg;
    result_t           rsp_data_reg;

    logic [19:0]          bitpos;
    logic [AW-1:0]        job_word;
    logic [2:0]           need;
    logic                 fits;
    logic                 out_free;
    logic                 go_access;
    logic                 go_repack;
    logic                 rp_done;
    logic                 rsp_set;
    logic [2:0]           shift_k;
    logic [WORD_BITS-1:0] acc_mask;
    logic [WORD_BITS-1:0] merged;
    logic [15:0]          extracted;
    logic                 mem_re;
    logic [AW-1:0]        mem_raddr;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;

    function automatic logic [WORD_BITS-1:0] slot_mask(input logic [2:0] code);
        logic [4:0] w;
        w = 5'd1 << code;
        return ~({WORD_BITS{1'b1}} << w);
    endfunction

    function automatic logic [WORD_BITS-1:0] expand(
        input logic [WORD_BITS-1:0] src,
        input logic [2:0]           oc,
        input logic [2:0]           nc,
        input logic [AW-1:0]        dst
    );
        logic [2:0]           k;
        int                   ci;
        int                   j;
        int                   wi;
        logic [LOG_WB-1:0]    sh;
        logic [LOG_WB-1:0]    idx;
        logic [WORD_BITS-1:0] slice;
        logic [WORD_BITS-1:0] res;
        k     = nc - oc;
        ci    = int'(dst) & ((1 << k) - 1);
        sh    = LOG_WB'(ci << (LOG_WB - int'(k)));
        slice = src >> sh;
        for (int b = 0; b < WORD_BITS; b++)
        begin
            j      = b >> nc;
            wi     = b & ((1 << nc) - 1);
            idx    = LOG_WB'((j << oc) + wi);
            res[b] = (wi < (1 << oc)) ? slice[idx] : 1'b0;
        end
        return res;
    endfunction

    assign bitpos    = 20'(job.position) << width_reg;
    assign job_word  = bitpos[LOG_WB +: AW];
    assign need      = required_code(job.distinct_count);
    assign fits      = value_fits(job.value, width_reg);
    assign out_free  = !rsp_vld_reg || rsp.ready;
    assign job_pop   = (state_reg == ST_IDLE) && job_vld && out_free;
    assign clearing  = (state_reg == ST_CLEAR);
    assign go_access = job.in_range
                     && ((job.op == CMD_READ) || ((job.op == CMD_WRITE) && fits));
    assign go_repack = (job.op == CMD_RESERVE) && (need > width_reg);
    assign rp_done   = rp_wvld_reg && !rp_issue_reg && (rp_waddr_reg == '0);
    assign shift_k   = new_code_reg - width_reg;
    assign acc_mask  = slot_mask(width_reg);
    assign extracted = 16'((rdata_reg >> acc_off_reg) & acc_mask);
    assign merged    = (rdata_reg & ~(acc_mask << acc_off_reg))
                     | ((WORD_BITS'(acc_reg.value) & acc_mask) << acc_off_reg);

    assign rsp.valid      = rsp_vld_reg;
    assign rsp.read_value = rsp_data_reg.read_value;
    assign rsp.status     = rsp_data_reg.status;
    assign rsp.width_code = rsp_data_reg.width_code;

    always_comb
    begin
        mem_re    = 1'b0;
        mem_raddr = job_word;
        mem_we    = 1'b0;
        mem_waddr = acc_word_reg;
        mem_wdata = merged;
        rsp_set   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
                mem_wdata = '0;
            end
            ST_IDLE:
            begin
                mem_re  = job_pop && go_access;
                rsp_set = job_pop && !go_access && !go_repack;
            end
            ST_ACCESS:
            begin
                mem_we  = (acc_reg.op == CMD_WRITE);
                rsp_set = 1'b1;
            end
            ST_REPACK:
            begin
                mem_re    = rp_issue_reg;
                mem_raddr = rp_addr_reg >> shift_k;
                mem_we    = rp_wvld_reg;
                mem_waddr = rp_waddr_reg;
                mem_wdata = expand(rdata_reg, width_reg, new_code_reg, rp_waddr_reg);
                rsp_set   = rp_done;
            end
            default:
            begin
                mem_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            width_reg    <= CODE_W1;
            new_code_reg <= CODE_W1;
            clr_addr_reg <= '0;
            rp_addr_reg  <= '0;
            rp_issue_reg <= 1'b0;
            rp_wvld_reg  <= 1'b0;
            rp_waddr_reg <= '0;
            acc_reg      <= '0;
            acc_word_reg <= '0;
            acc_off_reg  <= '0;
            rsp_vld_reg  <= 1'b0;
            rsp_data_reg <= '0;
        end
        else
        begin
            rsp_vld_reg <= rsp_set || (rsp_vld_reg && !rsp.ready);
            unique case (state_reg)
                ST_CLEAR:
                begin
                    if (clr_addr_reg == AW'(WORDS - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        clr_addr_reg <= clr_addr_reg + 1'b1;
                    end
                end
                ST_IDLE:
                begin
                    if (job_pop)
                    begin
                        acc_reg      <= job;
                        acc_word_reg <= job_word;
                        acc_off_reg  <= bitpos[LOG_WB-1:0];
                        rsp_data_reg <= '{read_value: 16'd0,
                                          status: (job.op == CMD_WRITE) && !fits,
                                          width_code: width_reg};
                        priority if (go_access)
                        begin
                            state_reg <= ST_ACCESS;
                        end
                        else if (go_repack)
                        begin
                            new_code_reg <= need;
                            rp_addr_reg  <= AW'((WORDS >> (4 - int'(need))) - 1);
                            rp_issue_reg <= 1'b1;
                            rp_wvld_reg  <= 1'b0;
                            state_reg    <= ST_REPACK;
                        end
                    end
                end
                ST_ACCESS:
                begin
                    if (acc_reg.op == CMD_READ)
                    begin
                        rsp_data_reg.read_value <= extracted;
                    end
                    state_reg <= ST_IDLE;
                end
                ST_REPACK:
                begin
                    rp_wvld_reg  <= rp_issue_reg;
                    rp_waddr_reg <= rp_addr_reg;
                    if (rp_issue_reg)
                    begin
                        if (rp_addr_reg == '0)
                        begin
                            rp_issue_reg <= 1'b0;
                        end
                        else
                        begin
                            rp_addr_reg <= rp_addr_reg - 1'b1;
                        end
                    end
                    if (rp_done)
                    begin
                        width_reg               <= new_code_reg;
                        rsp_data_reg.width_code <= new_code_reg;
                        state_reg               <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

/* rtl/vwpis_checker.sv */
// Port-level checks on the response channel of the packed index store.
// Depends on variable_width_packed_index_store_macros.svh; bound to the top level.
`include "variable_width_packed_index_store_macros.svh"

module vwpis_checker
    import vwpis_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [15:0] read_value,
    input logic        status,
    input logic [2:0]  width_code
);

    `VWPIS_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")
    `VWPIS_ASSERT_NXT(a_width_mono, rsp_valid && rsp_ready, !rsp_valid || (width_code >= $past(width_code)), "width shrank")
    `VWPIS_ASSERT_IMP(a_reject, rsp_valid && status, (width_code != CODE_W16) && (read_value == 16'd0), "bad rejection word")

endmodule

bind variable_width_packed_index_store vwpis_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .read_value (rsp.read_value),
    .status     (rsp.status),
    .width_code (rsp.width_code)
);

/* tb/vwpis_tb_checker.sv */
`timescale 1ns / 100ps
// Checker for the packed index store: watches req and rsp, predicts each result
// from its own copy of the store and width, and counts mismatches. Needs vwpis_pkg.
module vwpis_tb_checker
    import vwpis_pkg::*;
#(
    parameter int ENTRIES   = 32768,
    parameter int WORD_BITS = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    vwpis_req_if        req,
    vwpis_rsp_if        rsp,
    output int          fail_count,
    output int          pending_count,
    output int          reserve_widened
);
    localparam int STORE_WORDS = ENTRIES * 16 / WORD_BITS;

    logic [WORD_BITS-1:0] shadow_store [STORE_WORDS];
    logic [2:0]           shadow_width;
    result_t              expected_results [$];

    function automatic int slot_bits(input logic [2:0] code);
        return 1 << ((code > CODE_W16) ? 4 : code);
    endfunction

    function automatic logic [15:0] slot_read(input int pos, input logic [2:0] code);
        int w;
        int bitpos;
        logic [WORD_BITS-1:0] word;
        w = slot_bits(code);
        bitpos = pos * w;
        if (bitpos / WORD_BITS >= STORE_WORDS)
            return '0;
        word = shadow_store[bitpos / WORD_BITS] >> (bitpos % WORD_BITS);
        return 16'(word & ((64'd1 << w) - 1));
    endfunction

    task automatic slot_write(input int pos, input logic [2:0] code, input logic [15:0] v);
        int w;
        int bitpos;
        logic [WORD_BITS-1:0] m;
        w = slot_bits(code);
        bitpos = pos * w;
        if (bitpos / WORD_BITS >= STORE_WORDS)
            return;
        m = WORD_BITS'((64'd1 << w) - 1);
        shadow_store[bitpos / WORD_BITS] = (shadow_store[bitpos / WORD_BITS]
            & ~(m << (bitpos % WORD_BITS))) | ((WORD_BITS'(v) & m) << (bitpos % WORD_BITS));
    endtask

    function automatic logic [2:0] width_needed(input logic [15:0] cnt);
        if (cnt > 16'd256) return CODE_W16;
        if (cnt > 16'd16)  return CODE_W8;
        if (cnt > 16'd4)   return CODE_W4;
        if (cnt > 16'd2)   return CODE_W2;
        return CODE_W1;
    endfunction

    task automatic predict_word(input cmd_t op, input logic [14:0] pos,
                                input logic [15:0] val, input logic [15:0] cnt);
        result_t r;
        logic [2:0] need;
        r = '0;
        case (op)
            CMD_READ:
                if (int'(pos) < ENTRIES)
                    r.read_value = slot_read(pos, shadow_width);
            CMD_WRITE:
                if (shadow_width < CODE_W16 && int'(val) >= (1 << slot_bits(shadow_width)))
                    r.status = 1'b1;
                else if (int'(pos) < ENTRIES)
                    slot_write(pos, shadow_width, val);
            CMD_RESERVE:
            begin
                need = width_needed(cnt);
                if (need > shadow_width)
                begin
                    for (int i = ENTRIES - 1; i >= 0; i--)
                        slot_write(i, need, slot_read(i, shadow_width));
                    shadow_width = need;
                    reserve_widened++;
                end
            end
            default: ;
        endcase
        r.width_code = shadow_width;
        expected_results.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t e;
        if (!rst_n)
        begin
            foreach (shadow_store[i])
                shadow_store[i] = '0;
            shadow_width = CODE_W1;
            expected_results.delete();
            fail_count = 0;
            pending_count = 0;
            reserve_widened = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected word rv=%h st=%b wc=%0d", $time,
                             rsp.read_value, rsp.status, rsp.width_code);
                    fail_count++;
                end
                else
                begin
                    e = expected_results.pop_front();
                    if (rsp.read_value !== e.read_value)
                    begin
                        $display("%0t: read_value expected %h actual %h", $time,
                                 e.read_value, rsp.read_value);
                        fail_count++;
                    end
                    if (rsp.status !== e.status)
                    begin
                        $display("%0t: status expected %b actual %b", $time,
                                 e.status, rsp.status);
                        fail_count++;
                    end
                    if (rsp.width_code !== e.width_code)
                    begin
                        $display("%0t: width_code expected %0d actual %0d", $time,
                                 e.width_code, rsp.width_code);
                        fail_count++;
                    end
                end
            end
            if (req.valid && req.ready)
                predict_word(cmd_t'(req.command), req.position, req.value,
                             req.distinct_count);
            pending_count = expected_results.size();
        end
    end
endmodule

/* tb/tb_variable_width_packed_index_store.sv */
`timescale 1ns / 100ps
// Top of the packed index store testbench: clock, reset, stimulus and verdict.
// Needs vwpis_pkg, vwpis_if, the block and vwpis_tb_checker.
module tb_variable_width_packed_index_store;
    import vwpis_pkg::*;

    localparam int ENTRIES   = 32768;
    localparam int WORD_BITS = 64;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending_count;
    int   reserve_widened;
    int   cycle_count;
    int   words_sent;
    logic rx_hold;
    int   idle_mode;

    vwpis_req_if req ();
    vwpis_rsp_if rsp ();

    variable_width_packed_index_store #(.ENTRIES(ENTRIES), .WORD_BITS(WORD_BITS)) uut (
        .clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp)
    );

    vwpis_tb_checker #(.ENTRIES(ENTRIES), .WORD_BITS(WORD_BITS)) checker_i (
        .clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp), .fail_count(fail_count),
        .pending_count(pending_count), .reserve_widened(reserve_widened)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 3000000)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("simulation failed");
            $finish;
        end
    end

    // receiver: own stall pattern, long hold-off when asked
    always @(negedge clk)
    begin
        if (rx_hold)
            rsp.ready <= 1'b0;
        else if (idle_mode == 0)
            rsp.ready <= 1'b1;
        else
            rsp.ready <= ($urandom_range(0, 3) != 0);
    end

    task automatic send_word(input cmd_t op, input logic [14:0] pos,
                             input logic [15:0] val, input logic [15:0] cnt);
        req.valid          <= 1'b1;
        req.command        <= op;
        req.position       <= pos;
        req.value          <= val;
        req.distinct_count <= cnt;
        do
            @(posedge clk);
        while (!req.ready);
        words_sent++;
        @(negedge clk);
    endtask

    task automatic pause_sender(input int cycles);
        req.valid <= 1'b0;
        repeat (cycles)
            @(negedge clk);
    endtask

    task automatic drain_results;
        req.valid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
    endtask

    // random word: values drawn from mixed ranges, so some are oversized for the current width
    task automatic random_word(input int low_pos);
        int sel;
        logic [15:0] val;
        logic [14:0] pos;
        logic [15:0] cnt;
        sel = $urandom_range(0, 99);
        pos = (low_pos != 0) ? 15'($urandom_range(0, 63)) : 15'($urandom);
        if ($urandom_range(0, 9) == 0)
            pos = 15'($urandom_range(32700, 32767));
        case ($urandom_range(0, 3))
            0: val = 16'($urandom_range(0, 1));
            1: val = 16'($urandom_range(0, 15));
            2: val = 16'($urandom_range(0, 255));
            default: val = 16'($urandom);
        endcase
        cnt = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 20)) : 16'($urandom);
        if (sel < 45)
            send_word(CMD_READ, pos, val, cnt);
        else if (sel < 90)
            send_word(CMD_WRITE, pos, val, cnt);
        else if (sel < 93)
            send_word(CMD_NOP, pos, val, cnt);
        else
            send_word(CMD_RESERVE, pos, val, 16'($urandom_range(0, 3)));
    endtask

    initial
    begin
        int burst;
        rst_n              = 1'b0;
        cycle_count        = 0;
        words_sent         = 0;
        rx_hold            = 1'b0;
        idle_mode          = 0;
        req.valid          = 1'b0;
        req.command        = CMD_READ;
        req.position       = '0;
        req.value          = '0;
        req.distinct_count = '0;
        rsp.ready          = 1'b1;
        repeat (2)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_word(CMD_READ, 15'd0, 16'd0, 16'd0);
        send_word(CMD_WRITE, 15'd0, 16'd1, 16'd0);
        send_word(CMD_WRITE, 15'd32767, 16'd1, 16'd0);
        send_word(CMD_WRITE, 15'd5, 16'd2, 16'd0);
        send_word(CMD_WRITE, 15'd6, 16'hFFFF, 16'd0);
        send_word(CMD_RESERVE, 15'd0, 16'd0, 16'd0);
        send_word(CMD_RESERVE, 15'd0, 16'd0, 16'd2);
        send_word(CMD_NOP, 15'h7FFF, 16'hFFFF, 16'hFFFF);
        send_word(CMD_READ, 15'd32767, 16'd0, 16'd0);
        send_word(CMD_RESERVE, 15'd0, 16'd0, 16'd3);
        send_word(CMD_WRITE, 15'd1, 16'd3, 16'd0);
        send_word(CMD_WRITE, 15'd2, 16'd4, 16'd0);
        send_word(CMD_RESERVE, 15'd0, 16'd0, 16'd1);
        send_word(CMD_READ, 15'd0, 16'd0, 16'd0);
        send_word(CMD_READ, 15'd1, 16'd0, 16'd0);

        // random phase in the narrow widths
        for (int n = 0; n < 500; n++)
        begin
            if (n == 200)
                idle_mode = 1;
            random_word(n % 2);
            if ($urandom_range(0, 15) == 0)
                pause_sender($urandom_range(1, 6));
        end

        // long receiver hold-off while the sender keeps offering
        rx_hold <= 1'b1;
        fork
            begin
                repeat (40)
                    @(negedge clk);
                rx_hold <= 1'b0;
            end
            for (int n = 0; n < 12; n++)
                random_word(1);
        join
        drain_results();

        send_word(CMD_RESERVE, 15'd0, 16'd0, 16'd5);
        send_word(CMD_WRITE, 15'd32767, 16'd15, 16'd0);
        send_word(CMD_RESERVE, 15'd0, 16'd0, 16'd16);
        send_word(CMD_RESERVE, 15'd0, 16'd0, 16'd17);
        send_word(CMD_WRITE, 15'd3, 16'd255, 16'd0);
        send_word(CMD_WRITE, 15'd4, 16'd256, 16'd0);
        for (int n = 0; n < 500; n++)
        begin
            burst = $urandom_range(0, 7);
            random_word(n % 3 == 0);
            if (burst == 0)
                pause_sender($urandom_range(1, 5));
        end
        drain_results();

        send_word(CMD_RESERVE, 15'd0, 16'd0, 16'd256);
        send_word(CMD_RESERVE, 15'd0, 16'd0, 16'd257);
        send_word(CMD_WRITE, 15'd7, 16'hFFFF, 16'd0);
        send_word(CMD_RESERVE, 15'd0, 16'd0, 16'hFFFF);
        idle_mode = 0;
        for (int n = 0; n < 800; n++)
        begin
            if (n == 400)
                idle_mode = 1;
            random_word(n % 2);
            if ($urandom_range(0, 11) == 0)
                pause_sender($urandom_range(1, 8));
        end
        drain_results();
        repeat (50)
            @(negedge clk);

        $display("sent %0d words, %0d widening reserves, final width reached 16 bits",
                 words_sent, reserve_widened);
        if (fail_count == 0 && pending_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
